>>> src/tpds_pkg.sv
// Package for the thirteen-point diffusion stencil.
// Holds register indexes, reset values and the per-item index record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpds_pkg;

  typedef enum logic [1:0] {
    REG_INTERIOR_WIDTH  = 2'd0,
    REG_INTERIOR_HEIGHT = 2'd1,
    REG_HALO_WIDTH      = 2'd2,
    REG_ALPHA_Q         = 2'd3
  } reg_index_t;

  localparam int CFG_BITS = 16;
  localparam int IW_BITS = 10;
  localparam int IH_BITS = 16;
  localparam int HALO_BITS = 3;
  localparam int ALPHA_BITS = 16;
  localparam int ROW_CNT_BITS = 17;

  localparam logic [IW_BITS-1:0] IW_RESET = 10'd64;
  localparam logic [IH_BITS-1:0] IH_RESET = 16'd64;
  localparam logic [HALO_BITS-1:0] HALO_RESET = 3'd2;
  localparam logic [HALO_BITS-1:0] HALO_MIN = 3'd2;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd1966;

  typedef struct packed {
    logic                emit;
    logic [IW_BITS-1:0]  col_index;
    logic [IH_BITS-1:0]  row_index;
    logic                last_of_plane;
  } point_meta_t;

endpackage

`default_nettype wire

>>> src/tpds_col_cell.sv
// One column of the 5x5 window: five samples, loaded from the right neighbor.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tpds_col_cell #(
  parameter int SB = 32
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [5*SB-1:0]      col_in,
  output logic      [5*SB-1:0]      col_out
);

  logic [5*SB-1:0] col_r;

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

>>> src/tpds_kernel.sv
// Four-stage arithmetic of the stencil: tap sums, weighted sum, alpha product,
// rounding and saturation. Depends on tpds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpds_kernel
  import tpds_pkg::*;
#(
  parameter int SB = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_v,
  input  wire point_meta_t           in_meta,
  input  wire logic [25*SB-1:0]      win,
  input  wire logic [ALPHA_BITS-1:0] alpha,
  output logic                       res_v,
  output logic      [SB-1:0]         res_value,
  output point_meta_t                res_meta
);

  localparam int TW = SB + 8;
  localparam int HW = TW - 16;
  localparam int PW = HW + ALPHA_BITS + 1;
  localparam int RW = TW + 2;

  logic signed [SB-1:0] w [5][5];

  always_comb begin
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        w[y][x] = $signed(win[(x*5+y)*SB +: SB]);
      end
    end
  end

  logic signed [SB+1:0] ax_nxt, dg_nxt, fr_nxt;
  logic signed [SB+1:0] ax_r, dg_r, fr_r;
  logic signed [SB-1:0] ca_r, cb_r, cc_r;
  logic signed [TW-1:0] t_nxt, t_r;
  logic signed [PW-1:0] ph_nxt, ph_r;
  logic [16:0] fr16_nxt, fr16_r;
  logic [32:0] lo_prod;
  logic signed [RW-1:0] sum;
  logic [RW-SB:0] top_bits;
  logic [SB-1:0] sat;
  logic [3:0] v_r;
  point_meta_t m_r [4];
  logic [SB-1:0] value_r;

  assign ax_nxt = (SB+2)'(w[2][1]) + (SB+2)'(w[2][3]) + (SB+2)'(w[1][2]) + (SB+2)'(w[3][2]);
  assign dg_nxt = (SB+2)'(w[1][1]) + (SB+2)'(w[1][3]) + (SB+2)'(w[3][1]) + (SB+2)'(w[3][3]);
  assign fr_nxt = (SB+2)'(w[2][0]) + (SB+2)'(w[2][4]) + (SB+2)'(w[0][2]) + (SB+2)'(w[4][2]);

  assign t_nxt = (TW'(ax_r) <<< 3) - (TW'(dg_r) <<< 1) - TW'(fr_r)
               - (TW'(ca_r) <<< 4) - (TW'(ca_r) <<< 2);

  assign ph_nxt = PW'($signed({1'b0, alpha}) * $signed(t_r[TW-1:16]));
  assign lo_prod = 33'(alpha) * 33'(t_r[15:0]) + 33'd32768;
  assign fr16_nxt = lo_prod[32:16];

  assign sum = RW'(cc_r) + RW'(ph_r) + $signed(RW'({1'b0, fr16_r}));
  assign top_bits = sum[RW-1:SB-1];

  always_comb begin
    if (top_bits == '0 || top_bits == '1) begin
      sat = sum[SB-1:0];
    end else if (sum[RW-1]) begin
      sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt;
      dg_r <= dg_nxt;
      fr_r <= fr_nxt;
      ca_r <= w[2][2];
      m_r[0] <= in_meta;
      t_r <= t_nxt;
      cb_r <= ca_r;
      m_r[1] <= m_r[0];
      ph_r <= ph_nxt;
      fr16_r <= fr16_nxt;
      cc_r <= cb_r;
      m_r[2] <= m_r[1];
      value_r <= sat;
      m_r[3] <= m_r[2];
    end
  end

  assign res_v = v_r[3];
  assign res_value = value_r;
  assign res_meta = m_r[3];

endmodule

`default_nettype wire

>>> src/thirteen_point_diffusion_stencil.sv
// Top level of the thirteen-point diffusion stencil: raster counters, line
// buffer memory, window cell chain, kernel and output skid stage.
// Depends on tpds_pkg, tpds_col_cell and tpds_kernel.
//
// The block takes one sample per clock, halo included, while its skid stage
// is empty, and gives one result per interior point after the item that
// completes its window is accepted. The rate of one item per clock
// is set by the line buffer, whose single word holds the four buffered rows
// of a column and is read and rewritten once per sample, and by the window
// chain, which shifts one column per sample. The line buffer has no clearing
// pass; the first four rows of a plane fill it before use. Configuration
// must be written only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module thirteen_point_diffusion_stencil
  import tpds_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // Fields from bit 0: sample.
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // Fields from bit 0: value, col_index, row_index.
  output logic [((SAMPLE_BITS+26+7)/8)*8-1:0] out_tdata,
  output logic                      out_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_BITS-1:0]  cfg_wdata
);

  localparam int SB = SAMPLE_BITS;
  localparam int OW = ((SB + 26 + 7) / 8) * 8;
  localparam int AW = $clog2(MAX_ROW_LENGTH);
  localparam int LW = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int HW = ROW_CNT_BITS + 1;

  logic [IW_BITS-1:0] iw_r;
  logic [IH_BITS-1:0] ih_r;
  logic [HALO_BITS-1:0] halo_r;
  logic [ALPHA_BITS-1:0] alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= IW_RESET;
      ih_r <= IH_RESET;
      halo_r <= HALO_RESET;
      alpha_r <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_INTERIOR_WIDTH:  iw_r <= cfg_wdata[IW_BITS-1:0];
        REG_INTERIOR_HEIGHT: ih_r <= cfg_wdata[IH_BITS-1:0];
        REG_HALO_WIDTH:      halo_r <= cfg_wdata[HALO_BITS-1:0];
        REG_ALPHA_Q:         alpha_r <= cfg_wdata[ALPHA_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en, fire;
  logic [HALO_BITS-1:0] h;
  logic [LW-1:0] len_raw, len, nxe, c_ext, lo_c;
  logic [HW-1:0] hgt, r_ext, lo_r;
  logic [AW-1:0] col_cnt_r, col_cnt_nxt, cc;
  logic [ROW_CNT_BITS-1:0] row_cnt_r, row_cnt_nxt, rr;
  point_meta_t meta0;

  assign h = (halo_r < HALO_MIN) ? HALO_MIN : halo_r;
  assign len_raw = LW'(iw_r) + LW'({h, 1'b0});
  assign len = (len_raw > LW'(MAX_ROW_LENGTH)) ? LW'(MAX_ROW_LENGTH) : len_raw;
  assign nxe = len - LW'({h, 1'b0});
  assign hgt = HW'(ih_r) + HW'({h, 1'b0});
  assign cc = (LW'(col_cnt_r) >= len) ? '0 : col_cnt_r;
  assign rr = (HW'(row_cnt_r) >= hgt) ? '0 : row_cnt_r;
  assign c_ext = LW'(cc);
  assign r_ext = HW'(rr);
  assign lo_c = LW'(h) + LW'(2);
  assign lo_r = HW'(h) + HW'(2);

  always_comb begin
    meta0.emit = (c_ext >= lo_c) && (c_ext < lo_c + nxe)
              && (r_ext >= lo_r) && (r_ext < lo_r + HW'(ih_r));
    meta0.col_index = IW_BITS'(c_ext - lo_c);
    meta0.row_index = IH_BITS'(r_ext - lo_r);
    meta0.last_of_plane = (c_ext + LW'(1) == lo_c + nxe)
                       && (r_ext + HW'(1) == lo_r + HW'(ih_r));
    if (c_ext + LW'(1) >= len) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_ext + HW'(1) >= hgt) ? '0 : rr + ROW_CNT_BITS'(1);
    end else begin
      col_cnt_nxt = cc + AW'(1);
      row_cnt_nxt = rr;
    end
  end

  logic skid_v_r;
  assign en = !skid_v_r;
  assign in_tready = en;
  assign fire = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (fire) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  logic [4*SB-1:0] mem [MAX_ROW_LENGTH];
  logic [4*SB-1:0] rd_r;
  logic s1_v_r, s2_v_r;
  logic [SB-1:0] s1_sample_r;
  logic [AW-1:0] s1_addr_r;
  point_meta_t s1_meta_r, s2_meta_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r <= mem[cc];
    end
    if (en && s1_v_r) begin
      mem[s1_addr_r] <= {rd_r[3*SB-1:0], s1_sample_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= fire;
      s2_v_r <= s1_v_r && s1_meta_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_sample_r <= in_tdata[SB-1:0];
      s1_addr_r <= cc;
      s1_meta_r <= meta0;
    end
    if (en && s1_v_r) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  logic [5*SB-1:0] chain [6];
  logic [25*SB-1:0] win;
  logic shift_en;

  assign shift_en = en && s1_v_r;
  assign chain[5] = {s1_sample_r, rd_r[SB-1:0], rd_r[2*SB-1:SB],
                     rd_r[3*SB-1:2*SB], rd_r[4*SB-1:3*SB]};

  for (genvar k = 0; k < 5; k++) begin : g_cell
    tpds_col_cell #(.SB(SB)) u_cell (
      .clk(clk),
      .en(shift_en),
      .col_in(chain[k+1]),
      .col_out(chain[k])
    );
    assign win[k*5*SB +: 5*SB] = chain[k];
  end

  logic res_v;
  logic [SB-1:0] res_value;
  point_meta_t res_meta;

  tpds_kernel #(.SB(SB)) u_kernel (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .in_v(s2_v_r),
    .in_meta(s2_meta_r),
    .win(win),
    .alpha(alpha_r),
    .res_v(res_v),
    .res_value(res_value),
    .res_meta(res_meta)
  );

  logic out_v_r;
  logic [OW-1:0] out_data_r, skid_data_r;
  logic out_last_r, skid_last_r;
  logic res_fire;
  logic [OW-1:0] res_data;

  assign res_fire = res_v && en;
  assign res_data = OW'({res_meta.row_index, res_meta.col_index, res_value});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (res_fire) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_tready) begin
      if (res_fire) begin
        skid_data_r <= res_data;
        skid_last_r <= res_meta.last_of_plane;
      end
    end else if (skid_v_r) begin
      out_data_r <= skid_data_r;
      out_last_r <= skid_last_r;
    end else begin
      out_data_r <= res_data;
      out_last_r <= res_meta.last_of_plane;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

endmodule

`default_nettype wire
